// ===== src/rbai_pkg.sv =====
// Shared types and constants of the radar beam azimuth indexer.
package rbai_pkg;

  // Fixed field widths
  localparam int PRT_W  = 24;
  localparam int AZ_W   = 17;
  localparam int BAZ_W  = 16;
  localparam int STEP_W = 16;
  localparam int NREG_W = 9;
  localparam int PSB_W  = 16;
  localparam int DIV_W  = 18;

  // Angles in hundredths of a degree, times in ns
  localparam int FULL_TURN    = 36000;
  localparam int HALF_TURN    = 18000;
  localparam int PRT_TOL_NS   = 1000000;
  localparam int TIMEOUT_SHIFT = 4;

  // Register indexes
  localparam logic [1:0] REG_SAMPLES = 2'd0;
  localparam logic [1:0] REG_DUAL    = 2'd1;
  localparam logic [1:0] REG_INDEXED = 2'd2;
  localparam logic [1:0] REG_STEP    = 2'd3;

  typedef struct packed {
    logic [NREG_W-1:0] samples;
    logic              dual;
    logic              indexed;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic walk_init;
    logic walk;
    logic div_start;
    logic wrap_load_div;
    logic wrap_load_a1;
    logic wrap_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_ok;
    logic walk_done;
    logic div_done;
    logic wrap_done;
    logic out_free;
    logic indexed;
  } dp_stat_t;

endpackage

// ===== src/rbai_regs.sv =====
// Configuration register file with its APB-style access port.
module rbai_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output rbai_pkg::cfg_t    cfg
);
  import rbai_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[3:2];
  assign cfg   = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples <= NREG_W'(64);
      cfg_r.dual    <= 1'b0;
      cfg_r.indexed <= 1'b1;
      cfg_r.step    <= STEP_W'(100);
    end else if (wr_en) begin
      unique case (idx)
        REG_SAMPLES: cfg_r.samples <= pwdata[NREG_W-1:0];
        REG_DUAL:    cfg_r.dual    <= pwdata[0];
        REG_INDEXED: cfg_r.indexed <= pwdata[0];
        REG_STEP:    cfg_r.step    <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (idx)
      REG_SAMPLES: prdata = 32'(cfg_r.samples);
      REG_DUAL:    prdata = 32'(cfg_r.dual);
      REG_INDEXED: prdata = 32'(cfg_r.indexed);
      REG_STEP:    prdata = 32'(cfg_r.step);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== src/rbai_div.sv =====
// Restoring divider, one bit a cycle, giving the remainder only.
module rbai_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rbai_pkg::DIV_W-1:0]  dividend,
  input  logic [rbai_pkg::DIV_W-2:0]  divisor,
  output logic                        busy,
  output logic [rbai_pkg::DIV_W-2:0]  rem
);
  import rbai_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] num_r;
  logic [DIV_W-2:0] div_r;
  logic [DIV_W-2:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DIV_W-1:0] trial;
  logic [DIV_W-1:0] rem_nxt;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    trial = {rem_r, num_r[DIV_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = trial - {1'b0, div_r};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_W-2:0], 1'b0};
      rem_r <= rem_nxt[DIV_W-2:0];
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ===== src/rbai_dp.sv =====
// Datapath: pulse store, consistency walk, azimuth rounding and beam decision.
module rbai_dp #(
  parameter int MAX_SAMPLES = 256,
  parameter int GATE_BITS   = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rbai_pkg::ctrl_cmd_t                   cmd,
  output rbai_pkg::dp_stat_t                    stat,
  input  rbai_pkg::cfg_t                        cfg,
  input  logic [GATE_BITS-1:0]                  in_gate,
  input  logic [rbai_pkg::PRT_W-1:0]            in_prt,
  input  logic signed [rbai_pkg::AZ_W-1:0]      in_az,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_beam,
  output logic [rbai_pkg::BAZ_W-1:0]            out_az,
  output logic                                  out_gap
);
  import rbai_pkg::*;

  localparam int QDEPTH = MAX_SAMPLES + 1;
  localparam int AW     = $clog2(QDEPTH);
  localparam int FW     = $clog2(QDEPTH + 1);
  localparam int NW     = $clog2(MAX_SAMPLES + 1);

  typedef struct packed {
    logic [GATE_BITS-1:0]     gate;
    logic [PRT_W-1:0]         prt;
    logic signed [AZ_W-1:0]   az;
  } entry_t;

  entry_t                 mem [QDEPTH];
  entry_t                 head_r;
  entry_t                 rdata_r;
  logic [AW-1:0]          wp_r;
  logic [AW-1:0]          wp_nxt;
  logic [AW-1:0]          rd_addr_r;
  logic [NW-1:0]          rd_idx_r;
  logic [NW-1:0]          pend_idx_r;
  logic                   pend_r;
  logic                   mism_r;
  logic [FW-1:0]          fill_r;
  logic [PSB_W-1:0]       psb_r;
  logic signed [AZ_W-1:0] a1_r;
  logic signed [AZ_W-1:0] a2_r;
  logic signed [DIV_W-1:0] wv_r;
  logic                   neg_r;
  logic [DIV_W-1:0]       mag_r;
  logic [BAZ_W-1:0]       last_az_r;
  logic                   last_valid_r;
  logic                   out_valid_r;
  logic                   out_beam_r;
  logic [BAZ_W-1:0]       out_az_r;
  logic                   out_gap_r;

  logic [NW-1:0]          n;
  logic [NW-1:0]          half;
  logic [STEP_W-1:0]      r;
  logic                   issue;
  logic                   pend_bad;
  logic [PRT_W-1:0]       prt_diff;
  logic signed [DIV_W:0]  num_s;
  logic [DIV_W-1:0]       num_mag;
  logic [DIV_W-2:0]       rem;
  logic                   div_busy;
  logic [DIV_W-1:0]       tq;
  logic                   wrap_ok;
  logic [BAZ_W-1:0]       t;
  logic signed [DIV_W:0]  a1x;
  logic signed [DIV_W:0]  a2x;
  logic signed [DIV_W:0]  tx;
  logic signed [DIV_W:0]  rx;
  logic signed [DIV_W:0]  frx;
  logic                   straddle;
  logic                   zero_cross;
  logic                   timeout;
  logic                   mode_ok;
  logic                   beam;
  logic [BAZ_W-1:0]       dd;
  logic [BAZ_W-1:0]       dw;
  logic                   gap;
  logic                   load_out;

  // Clamp the pulse count and the resolution
  always_comb begin
    if (cfg.samples < NREG_W'(2)) begin
      n = NW'(2);
    end else if (32'(cfg.samples) > 32'(MAX_SAMPLES)) begin
      n = NW'(MAX_SAMPLES);
    end else begin
      n = NW'(cfg.samples);
    end
    r    = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
    half = n >> 1;
  end

  assign wp_nxt = (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;

  // Push the new pulse and count it; a beam clears the pulse count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      psb_r  <= '0;
    end else begin
      if (cmd.load) begin
        wp_r <= wp_nxt;
        if (fill_r < FW'(QDEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
        if (psb_r != '1) begin
          psb_r <= psb_r + 1'b1;
        end
      end else if (load_out && beam) begin
        psb_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wp_nxt] <= '{gate: in_gate, prt: in_prt, az: in_az};
      head_r      <= '{gate: in_gate, prt: in_prt, az: in_az};
    end
  end

  // Walk entries 1 to n-1, one read a cycle
  assign issue = rd_idx_r < n;

  always_ff @(posedge clk) begin
    if (cmd.walk && issue) begin
      rdata_r <= mem[rd_addr_r];
    end
  end

  always_comb begin
    prt_diff = (rdata_r.prt > head_r.prt) ? rdata_r.prt - head_r.prt
                                          : head_r.prt - rdata_r.prt;
    pend_bad = (rdata_r.gate != head_r.gate) || (32'(prt_diff) > PRT_TOL_NS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      rd_idx_r  <= '0;
      rd_addr_r <= '0;
      mism_r    <= 1'b0;
    end else if (cmd.walk_init) begin
      pend_r    <= 1'b0;
      rd_idx_r  <= NW'(1);
      rd_addr_r <= (wp_r == '0) ? AW'(QDEPTH - 1) : wp_r - 1'b1;
      mism_r    <= 1'b0;
    end else if (cmd.walk) begin
      pend_r <= issue;
      if (issue) begin
        rd_idx_r  <= rd_idx_r + 1'b1;
        rd_addr_r <= (rd_addr_r == '0) ? AW'(QDEPTH - 1) : rd_addr_r - 1'b1;
      end
      if (pend_r && pend_bad) begin
        mism_r <= 1'b1;
      end
    end
  end

  // Capture the two middle azimuths
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      a2_r <= head_r.az;
    end else if (cmd.walk && pend_r) begin
      if (pend_idx_r == half) begin
        a1_r <= rdata_r.az;
      end
      if (pend_idx_r == half - 1'b1) begin
        a2_r <= rdata_r.az;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk && issue) begin
      pend_idx_r <= rd_idx_r;
    end
  end

  // Round to the grid: remainder of |2*a1 + r| by 2*r
  always_comb begin
    num_s   = ((DIV_W + 1)'(a1_r) <<< 1) + $signed({3'b000, r});
    num_mag = num_s[DIV_W] ? DIV_W'(-num_s) : DIV_W'(num_s);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= num_s[DIV_W];
      mag_r <= num_mag;
    end
  end

  rbai_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_mag),
    .divisor  ({r, 1'b0}),
    .busy     (div_busy),
    .rem      (rem)
  );

  // Grid point times r is half of the remainder-free magnitude
  assign tq = (mag_r - {1'b0, rem}) >> 1;

  // Wrap into one turn, one add or subtract a cycle
  assign wrap_ok = (wv_r >= 0) && (wv_r < DIV_W'(FULL_TURN));

  always_ff @(posedge clk) begin
    if (cmd.wrap_load_div) begin
      wv_r <= neg_r ? -$signed(tq) : $signed(tq);
    end else if (cmd.wrap_load_a1) begin
      wv_r <= DIV_W'(a1_r);
    end else if (cmd.wrap_step && !wrap_ok) begin
      if (wv_r < 0) begin
        wv_r <= wv_r + DIV_W'(FULL_TURN);
      end else begin
        wv_r <= wv_r - DIV_W'(FULL_TURN);
      end
    end
  end

  // Decide the beam
  always_comb begin
    t          = wv_r[BAZ_W-1:0];
    a1x        = (DIV_W + 1)'(a1_r);
    a2x        = (DIV_W + 1)'(a2_r);
    tx         = $signed({3'b000, t});
    rx         = $signed({3'b000, r});
    frx        = (DIV_W + 1)'(FULL_TURN) - rx;
    straddle   = ((a1x <= tx) && (a2x >= tx)) || ((a1x >= tx) && (a2x <= tx));
    zero_cross = ((a1x > frx) && (a2x < rx)) || ((a2x > frx) && (a1x < rx));
    timeout    = 20'(psb_r) > (20'(n) << TIMEOUT_SHIFT);
    if (cfg.indexed) begin
      mode_ok = straddle || ((t == '0) ? zero_cross : timeout);
    end else begin
      mode_ok = 20'(psb_r) >= 20'(n);
    end
    beam = stat.fill_ok && !mism_r && mode_ok;
  end

  // Gap to the previous beam, taken the short way round
  always_comb begin
    dd  = (t >= last_az_r) ? t - last_az_r : last_az_r - t;
    dw  = (32'(dd) > HALF_TURN) ? BAZ_W'(FULL_TURN) - dd : dd;
    gap = last_valid_r && (dw > r);
  end

  // Output register
  assign load_out = cmd.finish && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      last_valid_r <= 1'b0;
      last_az_r    <= '0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_out && beam) begin
        last_valid_r <= 1'b1;
        last_az_r    <= t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_beam_r <= beam;
      out_az_r   <= beam ? t : '0;
      out_gap_r  <= beam && gap;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beam  = out_beam_r;
  assign out_az    = out_az_r;
  assign out_gap   = out_gap_r;

  // Status to the controller
  always_comb begin
    stat.fill_ok   = 32'(fill_r) >= 32'(n) + 32'(cfg.dual);
    stat.walk_done = !issue && !pend_r;
    stat.div_done  = !div_busy;
    stat.wrap_done = wrap_ok;
    stat.out_free  = !out_valid_r || out_ready;
    stat.indexed   = cfg.indexed;
  end

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < QDEPTH) else $error("write pointer beyond store");
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rd_addr_r) < QDEPTH) else $error("read address beyond store");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= QDEPTH) else $error("fill count overflow");
  a_psb_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && beam |=> psb_r == '0) else $error("pulse count not cleared on beam");

endmodule

// ===== src/rbai_ctrl.sv =====
// Controller state machine sequencing one pulse through the datapath.
module rbai_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbai_pkg::dp_stat_t   stat,
  output rbai_pkg::ctrl_cmd_t  cmd
);
  import rbai_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_WRAP   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.fill_ok) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          if (stat.indexed) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            cmd.wrap_load_a1 = 1'b1;
            state_nxt        = S_WRAP;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.wrap_load_div = 1'b1;
          state_nxt         = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.wrap_step = 1'b1;
        if (stat.wrap_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/radar_beam_azimuth_indexer.sv =====
// In indexed mode a pulse passes the load, check, walk, divide, wrap and finish states;
// unindexed skips the divide; with too few stored pulses it goes from check to finish.
// The walk reads n-1 stored pulses, one a cycle, where n is the pulses per beam, and the
// grid rounding uses a restoring remainder divider. One pulse is in work at a time; the
// next is taken the cycle after its result enters the output register.
// Reset is synchronous and active low; the store is not cleared, its fill count hides it.
module radar_beam_azimuth_indexer #(
  parameter int MAX_SAMPLES = 256,
  parameter int GATE_BITS   = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // gate_count [GATE_BITS-1:0], prt_ns [+24], azimuth_cdeg [+17], zero pad
  input  logic [((GATE_BITS+41+7)/8)*8-1:0]      in_tdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // beam_azimuth_cdeg [15:0], azimuth_gap [16], zero pad [23:17]
  output logic [23:0]                            out_tdata,
  // beam_ready [0]
  output logic [0:0]                             out_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [3:0]                             cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);
  import rbai_pkg::*;

  cfg_t              cfg;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic              beam;
  logic [BAZ_W-1:0]  baz;
  logic              gap;

  assign cfg_pready = 1'b1;

  rbai_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  rbai_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbai_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .GATE_BITS   (GATE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .in_gate   (in_tdata[GATE_BITS-1:0]),
    .in_prt    (in_tdata[GATE_BITS+PRT_W-1:GATE_BITS]),
    .in_az     ($signed(in_tdata[GATE_BITS+PRT_W+AZ_W-1:GATE_BITS+PRT_W])),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_beam  (beam),
    .out_az    (baz),
    .out_gap   (gap)
  );

  // Pack the result item
  assign out_tdata = {7'b0000000, gap, baz};
  assign out_tuser = beam;

endmodule
